// ===== rtl/dnp3dfr_pkg.sv =====
`timescale 1ns / 1ps

package dnp3dfr_pkg;

    localparam logic [15:0] CRC_POLY       = 16'hA6BC;
    localparam logic [15:0] CRC_FINAL_XOR  = 16'hFFFF;
    localparam logic [7:0]  START_OCTET_0  = 8'h05;
    localparam logic [7:0]  START_OCTET_1  = 8'h64;
    localparam logic [7:0]  MIN_LINK_LEN   = 8'd5;
    localparam logic [7:0]  MAX_USER_RESET = 8'd250;

    localparam int JQ_DEPTH = 2;
    localparam int JQ_AW    = 1;
    localparam int JQ_CW    = 2;
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_CW    = 3;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_START = 3'd1,
        ST_BAD_LEN   = 3'd2,
        ST_HDR_CRC   = 3'd3,
        ST_CAPACITY  = 3'd4,
        ST_BLK_CRC   = 3'd5,
        ST_TRUNC     = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        PH_RX   = 2'd0,
        PH_DONE = 2'd1,
        PH_FAIL = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        BLK_FILL   = 2'd0,
        BLK_CRC_LO = 2'd1,
        BLK_CRC_HI = 2'd2
    } t_blk_stage;

    typedef struct packed {
        logic        has_data;
        logic        bank;
        logic [7:0]  len;
        logic        has_report;
        t_status     status;
        logic [7:0]  link_length;
        logic [7:0]  control;
        logic [15:0] dest_addr;
        logic [15:0] src_addr;
        logic [7:0]  user_length;
    } t_job;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic        run_last;
        t_status     status;
        logic [7:0]  link_length;
        logic [7:0]  control;
        logic [15:0] dest_addr;
        logic [15:0] src_addr;
        logic [7:0]  user_length;
    } t_result;

    typedef struct packed {
        logic       job_full;
        logic [1:0] bank_release;
    } t_drain_stat;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

// ===== rtl/dnp3dfr_in_if.sv =====
`timescale 1ns / 1ps

interface dnp3dfr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] octet;
    logic       buffer_end;

    modport source (output valid, octet, buffer_end, input ready);
    modport sink   (input valid, octet, buffer_end, output ready);
endinterface

// ===== rtl/dnp3dfr_out_if.sv =====
`timescale 1ns / 1ps

interface dnp3dfr_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic        run_last;
    logic [2:0]  status;
    logic [7:0]  link_length;
    logic [7:0]  control;
    logic [15:0] dest_addr;
    logic [15:0] src_addr;
    logic [7:0]  user_length;

    modport source (output valid, kind, data_byte, run_last, status, link_length, control,
                    dest_addr, src_addr, user_length, input ready);
    modport sink   (input valid, kind, data_byte, run_last, status, link_length, control,
                    dest_addr, src_addr, user_length, output ready);
endinterface

// ===== rtl/dnp3dfr_ram.sv =====
`timescale 1ns / 1ps

module dnp3dfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/dnp3dfr_rx.sv =====
`timescale 1ns / 1ps

module dnp3dfr_rx
    import dnp3dfr_pkg::*;
#(
    parameter int BLOCK_BYTES = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    dnp3dfr_in_if.sink                           i_in,
    input  logic                                 i_cfg_we,
    input  logic [7:0]                           i_cfg_wdata,
    input  t_drain_stat                          i_stat,
    output logic                                 o_job_push,
    output t_job                                 o_job,
    output logic                                 o_ram_we,
    output logic [$clog2(2*BLOCK_BYTES)-1:0]     o_ram_waddr,
    output logic [7:0]                           o_ram_wdata
);

    localparam int AW = $clog2(2 * BLOCK_BYTES);
    localparam int LW = $clog2(BLOCK_BYTES + 1);

    localparam logic [3:0] POS_START0 = 4'd0;
    localparam logic [3:0] POS_START1 = 4'd1;
    localparam logic [3:0] POS_LEN    = 4'd2;
    localparam logic [3:0] POS_CTRL   = 4'd3;
    localparam logic [3:0] POS_DEST_L = 4'd4;
    localparam logic [3:0] POS_DEST_H = 4'd5;
    localparam logic [3:0] POS_SRC_L  = 4'd6;
    localparam logic [3:0] POS_SRC_H  = 4'd7;
    localparam logic [3:0] POS_CRC_L  = 4'd8;
    localparam logic [3:0] POS_CRC_H  = 4'd9;
    localparam logic [3:0] POS_BODY   = 4'd10;

    logic [3:0]  r_pos,      n_pos;
    t_phase      r_phase,    n_phase;
    t_blk_stage  r_stage,    n_stage;
    t_status     r_fail,     n_fail;
    logic [15:0] r_crc,      n_crc;
    logic [7:0]  r_user_rem, n_user_rem;
    logic [LW-1:0] r_fill,   n_fill;
    logic [LW-1:0] r_blk_len, n_blk_len;
    logic        r_bank,     n_bank;
    logic [1:0]  r_busy,     n_busy;
    logic [7:0]  r_max_len;
    logic [7:0]  r_crc_lo,   n_crc_lo;
    logic [7:0]  r_hdr_len,  n_hdr_len;
    logic [7:0]  r_hdr_ctrl, n_hdr_ctrl;
    logic [15:0] r_hdr_dest, n_hdr_dest;
    logic [15:0] r_hdr_src,  n_hdr_src;

    logic        accept;
    logic        bank_stall;
    logic [7:0]  b;
    logic [7:0]  ur_hdr;
    logic        hdr_crc_bad;
    logic        blk_crc_bad;
    logic [1:0]  busy_set;

    assign b           = i_in.octet;
    assign bank_stall  = (r_phase == PH_RX) && (r_pos == POS_BODY) && (r_stage == BLK_FILL)
                         && r_busy[r_bank];
    assign i_in.ready  = !i_stat.job_full && !bank_stall;
    assign accept      = i_in.valid && i_in.ready;
    assign ur_hdr      = r_hdr_len - MIN_LINK_LEN;
    assign hdr_crc_bad = {b, r_crc_lo} != (r_crc ^ CRC_FINAL_XOR);
    assign blk_crc_bad = hdr_crc_bad;

    always_comb begin
        n_pos      = r_pos;
        n_phase    = r_phase;
        n_stage    = r_stage;
        n_fail     = r_fail;
        n_crc      = r_crc;
        n_user_rem = r_user_rem;
        n_fill     = r_fill;
        n_blk_len  = r_blk_len;
        n_bank     = r_bank;
        n_crc_lo   = r_crc_lo;
        n_hdr_len  = r_hdr_len;
        n_hdr_ctrl = r_hdr_ctrl;
        n_hdr_dest = r_hdr_dest;
        n_hdr_src  = r_hdr_src;
        busy_set   = 2'b00;
        o_job_push = 1'b0;
        o_job      = '0;
        o_ram_we   = 1'b0;
        o_ram_waddr = (r_bank ? AW'(BLOCK_BYTES) : AW'(0)) + AW'(r_fill);
        o_ram_wdata = b;

        if (accept && r_phase == PH_RX) begin
            if (r_pos != POS_BODY) begin
                if (r_pos < POS_CRC_L) begin
                    n_crc = crc_byte(r_crc, b);
                end
                n_pos = r_pos + 4'd1;
                unique case (r_pos)
                    POS_START0: begin
                        if (b != START_OCTET_0) begin
                            n_phase = PH_FAIL;
                            n_fail  = ST_BAD_START;
                        end
                    end
                    POS_START1: begin
                        if (b != START_OCTET_1) begin
                            n_phase = PH_FAIL;
                            n_fail  = ST_BAD_START;
                        end
                    end
                    POS_LEN: begin
                        n_hdr_len = b;
                        if (b < MIN_LINK_LEN) begin
                            n_phase = PH_FAIL;
                            n_fail  = ST_BAD_LEN;
                        end
                    end
                    POS_CTRL:   n_hdr_ctrl = b;
                    POS_DEST_L: n_hdr_dest[7:0] = b;
                    POS_DEST_H: n_hdr_dest[15:8] = b;
                    POS_SRC_L:  n_hdr_src[7:0] = b;
                    POS_SRC_H:  n_hdr_src[15:8] = b;
                    POS_CRC_L:  n_crc_lo = b;
                    POS_CRC_H: begin
                        if (hdr_crc_bad) begin
                            n_phase = PH_FAIL;
                            n_fail  = ST_HDR_CRC;
                        end else begin
                            n_user_rem = ur_hdr;
                            if (ur_hdr > r_max_len) begin
                                n_phase = PH_FAIL;
                                n_fail  = ST_CAPACITY;
                            end else if (ur_hdr == 8'd0) begin
                                n_phase = PH_DONE;
                            end else begin
                                n_blk_len = (ur_hdr < 8'(BLOCK_BYTES)) ? LW'(ur_hdr)
                                                                       : LW'(BLOCK_BYTES);
                                n_fill    = '0;
                                n_crc     = '0;
                                n_stage   = BLK_FILL;
                            end
                        end
                    end
                    default: ;
                endcase
            end else begin
                unique case (r_stage)
                    BLK_FILL: begin
                        o_ram_we = 1'b1;
                        n_crc    = crc_byte(r_crc, b);
                        n_fill   = r_fill + LW'(1);
                        if (n_fill == r_blk_len) begin
                            n_stage = BLK_CRC_LO;
                        end
                    end
                    BLK_CRC_LO: begin
                        n_crc_lo = b;
                        n_stage  = BLK_CRC_HI;
                    end
                    BLK_CRC_HI: begin
                        if (blk_crc_bad) begin
                            n_phase = PH_FAIL;
                            n_fail  = ST_BLK_CRC;
                        end else begin
                            o_job_push     = 1'b1;
                            o_job.has_data = 1'b1;
                            o_job.bank     = r_bank;
                            o_job.len      = 8'(r_blk_len);
                            busy_set[r_bank] = 1'b1;
                            n_bank         = !r_bank;
                            n_user_rem     = r_user_rem - 8'(r_blk_len);
                            if (n_user_rem == 8'd0) begin
                                n_phase = PH_DONE;
                            end else begin
                                n_blk_len = (n_user_rem < 8'(BLOCK_BYTES)) ? LW'(n_user_rem)
                                                                           : LW'(BLOCK_BYTES);
                                n_fill    = '0;
                                n_crc     = '0;
                                n_stage   = BLK_FILL;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end

        if (accept && i_in.buffer_end) begin
            o_job_push       = 1'b1;
            o_job.has_report = 1'b1;
            if (n_phase == PH_DONE) begin
                o_job.status      = ST_OK;
                o_job.link_length = n_hdr_len;
                o_job.control     = n_hdr_ctrl;
                o_job.dest_addr   = n_hdr_dest;
                o_job.src_addr    = n_hdr_src;
                o_job.user_length = n_hdr_len - MIN_LINK_LEN;
            end else begin
                o_job.status = (n_phase == PH_FAIL) ? n_fail : ST_TRUNC;
            end
            n_pos      = POS_START0;
            n_phase    = PH_RX;
            n_stage    = BLK_FILL;
            n_fail     = ST_OK;
            n_crc      = '0;
            n_user_rem = '0;
            n_fill     = '0;
            n_blk_len  = '0;
        end

        n_busy = (r_busy & ~i_stat.bank_release) | busy_set;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= POS_START0;
            r_phase    <= PH_RX;
            r_stage    <= BLK_FILL;
            r_fail     <= ST_OK;
            r_crc      <= '0;
            r_user_rem <= '0;
            r_fill     <= '0;
            r_blk_len  <= '0;
            r_bank     <= 1'b0;
            r_busy     <= 2'b00;
            r_max_len  <= MAX_USER_RESET;
        end else begin
            r_pos      <= n_pos;
            r_phase    <= n_phase;
            r_stage    <= n_stage;
            r_fail     <= n_fail;
            r_crc      <= n_crc;
            r_user_rem <= n_user_rem;
            r_fill     <= n_fill;
            r_blk_len  <= n_blk_len;
            r_bank     <= n_bank;
            r_busy     <= n_busy;
            if (i_cfg_we) begin
                r_max_len <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_crc_lo   <= n_crc_lo;
        r_hdr_len  <= n_hdr_len;
        r_hdr_ctrl <= n_hdr_ctrl;
        r_hdr_dest <= n_hdr_dest;
        r_hdr_src  <= n_hdr_src;
    end

endmodule

// ===== rtl/dnp3dfr_drain.sv =====
`timescale 1ns / 1ps

module dnp3dfr_drain
    import dnp3dfr_pkg::*;
#(
    parameter int BLOCK_BYTES = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_job_push,
    input  t_job                             i_job,
    output t_drain_stat                      o_stat,
    output logic                             o_ram_re,
    output logic [$clog2(2*BLOCK_BYTES)-1:0] o_ram_raddr,
    input  logic [7:0]                       i_ram_rdata,
    dnp3dfr_out_if.source                    o_out
);

    localparam int AW = $clog2(2 * BLOCK_BYTES);
    localparam int LW = $clog2(BLOCK_BYTES + 1);

    t_job            r_jq [JQ_DEPTH];
    logic [JQ_AW-1:0] r_jq_rd, r_jq_wr;
    logic [JQ_CW-1:0] r_jq_cnt, n_jq_cnt;
    logic [LW-1:0]   r_idx, n_idx;

    logic            r_s1_valid;
    t_result         r_s1, n_s1;

    t_result         r_oq [OQ_DEPTH];
    logic [OQ_AW-1:0] r_oq_rd, r_oq_wr;
    logic [OQ_CW-1:0] r_oq_cnt, n_oq_cnt;

    t_job            head;
    logic            has_job;
    logic            space;
    logic            issue;
    logic            in_data;
    logic            last_data;
    logic            jq_pop;
    logic            oq_pop;
    logic [1:0]      release_bank;
    t_result         oq_item;
    t_result         oq_head;

    assign head      = r_jq[r_jq_rd];
    assign has_job   = r_jq_cnt != '0;
    assign space     = (r_oq_cnt + OQ_CW'(r_s1_valid)) < OQ_CW'(OQ_DEPTH);
    assign issue     = has_job && space;
    assign in_data   = head.has_data && (8'(r_idx) != head.len);
    assign last_data = (8'(r_idx) + 8'd1) == head.len;

    always_comb begin
        o_ram_re     = 1'b0;
        o_ram_raddr  = (head.bank ? AW'(BLOCK_BYTES) : AW'(0)) + AW'(r_idx);
        n_s1         = '0;
        n_idx        = r_idx;
        jq_pop       = 1'b0;
        release_bank = 2'b00;
        if (issue) begin
            if (in_data) begin
                o_ram_re      = 1'b1;
                n_s1.kind     = KIND_DATA;
                n_s1.run_last = last_data && !head.has_report;
                n_idx         = r_idx + LW'(1);
                if (last_data) begin
                    release_bank[head.bank] = 1'b1;
                    if (!head.has_report) begin
                        jq_pop = 1'b1;
                        n_idx  = '0;
                    end
                end
            end else begin
                n_s1.kind        = KIND_REPORT;
                n_s1.run_last    = 1'b1;
                n_s1.status      = head.status;
                n_s1.link_length = head.link_length;
                n_s1.control     = head.control;
                n_s1.dest_addr   = head.dest_addr;
                n_s1.src_addr    = head.src_addr;
                n_s1.user_length = head.user_length;
                jq_pop           = 1'b1;
                n_idx            = '0;
            end
        end
    end

    always_comb begin
        oq_item = r_s1;
        if (r_s1.kind == KIND_DATA) begin
            oq_item.data_byte = i_ram_rdata;
        end
    end

    assign oq_pop   = o_out.valid && o_out.ready;
    assign n_jq_cnt = r_jq_cnt + JQ_CW'(i_job_push) - JQ_CW'(jq_pop);
    assign n_oq_cnt = r_oq_cnt + OQ_CW'(r_s1_valid) - OQ_CW'(oq_pop);

    assign o_stat.job_full     = r_jq_cnt == JQ_CW'(JQ_DEPTH);
    assign o_stat.bank_release = release_bank;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jq_rd    <= '0;
            r_jq_wr    <= '0;
            r_jq_cnt   <= '0;
            r_idx      <= '0;
            r_s1_valid <= 1'b0;
            r_oq_rd    <= '0;
            r_oq_wr    <= '0;
            r_oq_cnt   <= '0;
        end else begin
            r_jq_cnt   <= n_jq_cnt;
            r_idx      <= n_idx;
            r_s1_valid <= issue;
            r_oq_cnt   <= n_oq_cnt;
            if (i_job_push) begin
                r_jq_wr <= r_jq_wr + JQ_AW'(1);
            end
            if (jq_pop) begin
                r_jq_rd <= r_jq_rd + JQ_AW'(1);
            end
            if (r_s1_valid) begin
                r_oq_wr <= r_oq_wr + OQ_AW'(1);
            end
            if (oq_pop) begin
                r_oq_rd <= r_oq_rd + OQ_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job_push) begin
            r_jq[r_jq_wr] <= i_job;
        end
        if (issue) begin
            r_s1 <= n_s1;
        end
        if (r_s1_valid) begin
            r_oq[r_oq_wr] <= oq_item;
        end
    end

    assign oq_head           = r_oq[r_oq_rd];
    assign o_out.valid       = r_oq_cnt != '0;
    assign o_out.kind        = oq_head.kind;
    assign o_out.data_byte   = oq_head.data_byte;
    assign o_out.run_last    = oq_head.run_last;
    assign o_out.status      = oq_head.status;
    assign o_out.link_length = oq_head.link_length;
    assign o_out.control     = oq_head.control;
    assign o_out.dest_addr   = oq_head.dest_addr;
    assign o_out.src_addr    = oq_head.src_addr;
    assign o_out.user_length = oq_head.user_length;

endmodule

// ===== rtl/dnp3_link_deframer.sv =====
// Path: a verified data block or frame report goes via the job queue, read stage and output
//   queue to o_out after its last octet (block CRC high octet or buffer end) is accepted.
// Throughput: one octet per cycle; data leaves a two-bank block RAM one byte per cycle while o_out.ready is high.
//   Input waits while both job slots are full or the bank to be filled is still draining.
// Reset: i_rst_n synchronous, active low; clears frame state and queues, max_user_len = 250.
`timescale 1ns / 1ps

module dnp3_link_deframer
    import dnp3dfr_pkg::*;
#(
    parameter int BLOCK_BYTES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dnp3dfr_in_if.sink    i_in,
    dnp3dfr_out_if.source o_out,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_wdata
);

    localparam int AW = $clog2(2 * BLOCK_BYTES);

    t_drain_stat   stat;
    logic          job_push;
    t_job          job;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;

    dnp3dfr_rx #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_rx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_stat      (stat),
        .o_job_push  (job_push),
        .o_job       (job),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata)
    );

    dnp3dfr_ram #(
        .WIDTH (8),
        .DEPTH (2 * BLOCK_BYTES)
    ) u_blk_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    dnp3dfr_drain #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_drain (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_push  (job_push),
        .i_job       (job),
        .o_stat      (stat),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_out       (o_out)
    );

    // a bank being drained is never written
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("block ram write hits an address being drained");

    a_job_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        job_push |-> !stat.job_full)
        else $error("job queue overflow");

    a_report_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == KIND_REPORT) |-> o_out.run_last)
        else $error("frame report not marked last");

endmodule

// ===== test/dnp3dfr_checker.sv =====
`timescale 1ns / 1ps

module dnp3dfr_checker
    import dnp3dfr_pkg::*;
#(
    parameter int BLOCK_BYTES = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dnp3dfr_in_if      i_in,
    dnp3dfr_out_if     i_out,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    output int         o_errors,
    output int         o_pending
);

    localparam int HDR_OCTETS = 10;
    localparam int BW         = $clog2(BLOCK_BYTES);

    logic [7:0]  user_cap;
    int unsigned octet_idx;
    t_phase      frame_phase;
    t_blk_stage  blk_stage;
    t_status     fail_status;
    logic [15:0] crc_acc;
    logic [7:0]  crc_lo;
    logic [7:0]  hdr_len;
    logic [7:0]  hdr_ctrl;
    logic [15:0] hdr_dest;
    logic [15:0] hdr_src;
    logic [7:0]  data_left;
    logic [7:0]  blk_cnt;
    logic [7:0]  blk_size;
    logic [7:0]  blk_buf [BLOCK_BYTES];

    t_result due_results[$];
    int      err_count = 0;
    int      due_count = 0;

    assign o_errors  = err_count;
    assign o_pending = due_count;

    function automatic logic [15:0] dnp_crc_step(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] r;
        r = acc ^ {8'h00, b};
        repeat (8) begin
            r = r[0] ? ({1'b0, r[15:1]} ^ CRC_POLY) : {1'b0, r[15:1]};
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
        end
    endtask

    task automatic restart_frame();
        octet_idx   = 0;
        frame_phase = PH_RX;
        blk_stage   = BLK_FILL;
        fail_status = ST_OK;
        crc_acc     = '0;
        crc_lo      = '0;
        hdr_len     = '0;
        hdr_ctrl    = '0;
        hdr_dest    = '0;
        hdr_src     = '0;
        data_left   = '0;
        blk_cnt     = '0;
        blk_size    = '0;
    endtask

    task automatic latch_failure(input t_status code);
        frame_phase = PH_FAIL;
        fail_status = code;
    endtask

    task automatic open_block();
        blk_size  = (data_left < 8'(BLOCK_BYTES)) ? data_left : 8'(BLOCK_BYTES);
        blk_cnt   = '0;
        crc_acc   = '0;
        blk_stage = BLK_FILL;
    endtask

    task automatic take_header_octet(input logic [7:0] b);
        if (octet_idx < 8) begin
            crc_acc = dnp_crc_step(crc_acc, b);
        end
        case (octet_idx)
            0: begin
                if (b != START_OCTET_0) latch_failure(ST_BAD_START);
            end
            1: begin
                if (b != START_OCTET_1) latch_failure(ST_BAD_START);
            end
            2: begin
                hdr_len = b;
                if (b < MIN_LINK_LEN) latch_failure(ST_BAD_LEN);
            end
            3: hdr_ctrl = b;
            4: hdr_dest[7:0] = b;
            5: hdr_dest[15:8] = b;
            6: hdr_src[7:0] = b;
            7: hdr_src[15:8] = b;
            8: crc_lo = b;
            default: begin
                if ({b, crc_lo} != (crc_acc ^ CRC_FINAL_XOR)) begin
                    latch_failure(ST_HDR_CRC);
                end else begin
                    data_left = hdr_len - MIN_LINK_LEN;
                    if (data_left > user_cap && data_left != 0) begin
                        latch_failure(ST_CAPACITY);
                    end else if (data_left == 0) begin
                        frame_phase = PH_DONE;
                    end else begin
                        open_block();
                    end
                end
            end
        endcase
        octet_idx++;
    endtask

    task automatic deframe_octet(input logic [7:0] b, input logic last);
        t_result r;
        int      first_new;
        first_new = due_results.size();
        if (frame_phase == PH_RX) begin
            if (octet_idx < HDR_OCTETS) begin
                take_header_octet(b);
            end else if (blk_stage == BLK_FILL) begin
                if (blk_cnt < blk_size) begin
                    blk_buf[blk_cnt[BW-1:0]] = b;
                    crc_acc = dnp_crc_step(crc_acc, b);
                    blk_cnt++;
                end
                if (blk_cnt >= blk_size) blk_stage = BLK_CRC_LO;
            end else if (blk_stage == BLK_CRC_LO) begin
                crc_lo    = b;
                blk_stage = BLK_CRC_HI;
            end else begin
                if ({b, crc_lo} != (crc_acc ^ CRC_FINAL_XOR)) begin
                    latch_failure(ST_BLK_CRC);
                end else begin
                    for (int i = 0; i < blk_size; i++) begin
                        r           = '0;
                        r.kind      = KIND_DATA;
                        r.data_byte = blk_buf[BW'(i)];
                        r.status    = ST_OK;
                        due_results.push_back(r);
                    end
                    data_left = (data_left >= blk_size) ? data_left - blk_size : 8'd0;
                    if (data_left == 0) frame_phase = PH_DONE;
                    else open_block();
                end
            end
        end
        if (last) begin
            r      = '0;
            r.kind = KIND_REPORT;
            if (frame_phase == PH_DONE) begin
                r.status      = ST_OK;
                r.link_length = hdr_len;
                r.control     = hdr_ctrl;
                r.dest_addr   = hdr_dest;
                r.src_addr    = hdr_src;
                r.user_length = hdr_len - MIN_LINK_LEN;
            end else begin
                r.status = (frame_phase == PH_FAIL) ? fail_status : ST_TRUNC;
            end
            due_results.push_back(r);
            restart_frame();
        end
        if (due_results.size() > first_new) begin
            r = due_results.pop_back();
            r.run_last = 1'b1;
            due_results.push_back(r);
        end
    endtask

    task automatic check_result();
        t_result want;
        if (due_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result, kind %0d status %0d",
                                      i_out.kind, i_out.status));
        end else begin
            want = due_results.pop_front();
            check_field("kind", 16'(i_out.kind), 16'(want.kind));
            check_field("data_byte", 16'(i_out.data_byte), 16'(want.data_byte));
            check_field("run_last", 16'(i_out.run_last), 16'(want.run_last));
            check_field("status", 16'(i_out.status), 16'(want.status));
            check_field("link_length", 16'(i_out.link_length), 16'(want.link_length));
            check_field("control", 16'(i_out.control), 16'(want.control));
            check_field("dest_addr", i_out.dest_addr, want.dest_addr);
            check_field("src_addr", i_out.src_addr, want.src_addr);
            check_field("user_length", 16'(i_out.user_length), 16'(want.user_length));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            user_cap = MAX_USER_RESET;
            restart_frame();
            due_results.delete();
        end else begin
            if (i_cfg_we) user_cap = i_cfg_wdata;
            if (i_out.valid && i_out.ready) check_result();
            if (i_in.valid && i_in.ready) deframe_octet(i_in.octet, i_in.buffer_end);
        end
        due_count = due_results.size();
    end

endmodule

// ===== test/tb_dnp3_link_deframer.sv =====
`timescale 1ns / 1ps

module tb_dnp3_link_deframer;
    import dnp3dfr_pkg::*;

    localparam int BLOCK_BYTES   = 16;
    localparam int PHASE_OCTETS  = 30;
    localparam int SETTLE_CYCLES = 6;
    localparam int DRAIN_CYCLES  = 20;
    localparam int LONG_HOLD     = 200;

    typedef enum {RX_FREE, RX_MOSTLY, RX_SPARSE, RX_PATTERN} t_rx_mode;
    typedef enum {
        FR_GOOD, FR_TRAILING, FR_TRUNCATED, FR_HDR_CRC, FR_BLK_CRC,
        FR_BAD_START, FR_BAD_LEN, FR_OVER_CAP, FR_NOISE
    } t_frame_kind;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [7:0] cfg_wdata;
    int         errors;
    int         pending;
    int         hold_reqs = 0;
    int         burst_left = 0;
    int         octets_sent = 0;
    logic [7:0] user_cap_now = MAX_USER_RESET;
    logic [7:0] frame_q[$];

    dnp3dfr_in_if  in_ch ();
    dnp3dfr_out_if out_ch ();

    dnp3_link_deframer #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .o_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    dnp3dfr_checker #(
        .BLOCK_BYTES (BLOCK_BYTES)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // receiver: random stall patterns, plus a long hold-off on request
    initial begin
        t_rx_mode   rx_mode;
        int         rx_left;
        int         hold_left;
        int         holds_taken;
        logic [7:0] rx_pat;
        out_ch.ready = 1'b0;
        rx_mode     = RX_FREE;
        rx_left     = 0;
        hold_left   = 0;
        holds_taken = 0;
        rx_pat      = '0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (hold_reqs != holds_taken) begin
                holds_taken++;
                hold_left = LONG_HOLD;
                out_ch.ready <= 1'b0;
            end else begin
                if (rx_left == 0) begin
                    rx_mode = t_rx_mode'($urandom_range(0, 3));
                    rx_left = $urandom_range(20, 60);
                    rx_pat  = 8'($urandom);
                end
                rx_left--;
                case (rx_mode)
                    RX_FREE:   out_ch.ready <= 1'b1;
                    RX_MOSTLY: out_ch.ready <= ($urandom_range(0, 3) != 0);
                    RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default: begin
                        out_ch.ready <= rx_pat[0];
                        rx_pat = {rx_pat[0], rx_pat[7:1]};
                    end
                endcase
            end
        end
    end

    function automatic logic [15:0] crc_next(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) c = (c >> 1) ^ CRC_POLY;
            else c = c >> 1;
        end
        return c;
    endfunction

    // called at a falling edge; returns at the falling edge after the transaction
    task automatic send_octet(input logic [7:0] b, input logic last);
        int gap;
        if (burst_left == 0) begin
            gap        = $urandom_range(0, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        in_ch.valid      <= 1'b1;
        in_ch.octet      <= b;
        in_ch.buffer_end <= last;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        octets_sent++;
        @(negedge clk);
    endtask

    task automatic send_buffer();
        foreach (frame_q[i]) begin
            send_octet(frame_q[i], i == frame_q.size() - 1);
        end
    endtask

    task automatic build_frame(input int ulen, input logic [7:0] ctrl,
                               input logic [15:0] dest, input logic [15:0] src);
        logic [15:0] acc;
        logic [7:0]  b;
        int          left;
        int          chunk;
        frame_q = {START_OCTET_0, START_OCTET_1, 8'(ulen + 5), ctrl,
                   dest[7:0], dest[15:8], src[7:0], src[15:8]};
        acc = '0;
        foreach (frame_q[i]) acc = crc_next(acc, frame_q[i]);
        acc ^= CRC_FINAL_XOR;
        frame_q.push_back(acc[7:0]);
        frame_q.push_back(acc[15:8]);
        left = ulen;
        while (left > 0) begin
            chunk = (left < BLOCK_BYTES) ? left : BLOCK_BYTES;
            acc   = '0;
            repeat (chunk) begin
                b   = 8'($urandom);
                acc = crc_next(acc, b);
                frame_q.push_back(b);
            end
            acc ^= CRC_FINAL_XOR;
            frame_q.push_back(acc[7:0]);
            frame_q.push_back(acc[15:8]);
            left -= chunk;
        end
    endtask

    task automatic cut_frame(input int keep);
        while (frame_q.size() > keep) void'(frame_q.pop_back());
    endtask

    task automatic random_buffer();
        t_frame_kind kind;
        int          pick;
        int          ulen;
        int          idx;
        pick = $urandom_range(0, 99);
        if (pick < 40)      kind = FR_GOOD;
        else if (pick < 48) kind = FR_TRAILING;
        else if (pick < 56) kind = FR_TRUNCATED;
        else if (pick < 64) kind = FR_HDR_CRC;
        else if (pick < 74) kind = FR_BLK_CRC;
        else if (pick < 80) kind = FR_BAD_START;
        else if (pick < 85) kind = FR_BAD_LEN;
        else if (pick < 93) kind = FR_OVER_CAP;
        else                kind = FR_NOISE;

        pick = $urandom_range(0, 99);
        if (pick < 60)      ulen = $urandom_range(0, 20);
        else if (pick < 90) ulen = $urandom_range(14, 34);
        else if (pick < 98) ulen = $urandom_range(35, 80);
        else                ulen = $urandom_range(200, 250);
        if (kind == FR_BLK_CRC && ulen == 0) ulen = 1;
        if (kind == FR_OVER_CAP && user_cap_now < 250) begin
            ulen = $urandom_range(user_cap_now + 1,
                                  (user_cap_now + 20 > 250) ? 250 : user_cap_now + 20);
        end

        build_frame(ulen, 8'($urandom), 16'($urandom), 16'($urandom));
        case (kind)
            FR_TRAILING: begin
                repeat ($urandom_range(1, 5)) frame_q.push_back(8'($urandom));
            end
            FR_TRUNCATED: cut_frame($urandom_range(1, frame_q.size() - 1));
            FR_HDR_CRC: begin
                idx = $urandom_range(3, 9);
                frame_q[idx] ^= 8'(1 << $urandom_range(0, 7));
            end
            FR_BLK_CRC: begin
                idx = $urandom_range(10, frame_q.size() - 1);
                frame_q[idx] ^= 8'(1 << $urandom_range(0, 7));
            end
            FR_BAD_START: begin
                idx = $urandom_range(0, 1);
                frame_q[idx] ^= 8'(1 << $urandom_range(0, 7));
            end
            FR_BAD_LEN: frame_q[2] = 8'($urandom_range(0, 4));
            FR_NOISE: begin
                frame_q.delete();
                repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom));
            end
            default: ;
        endcase
        // errored frames sometimes end early too, before or after the bad octet
        if ((kind == FR_HDR_CRC || kind == FR_BLK_CRC || kind == FR_BAD_START ||
             kind == FR_BAD_LEN) && $urandom_range(0, 2) == 0) begin
            cut_frame($urandom_range(1, frame_q.size()));
        end
        send_buffer();
    endtask

    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_cap(input logic [7:0] value);
        cfg_wdata <= value;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        user_cap_now = value;
    endtask

    initial begin
        logic [7:0] cap_list[5];
        int         phase_end;
        int         octet_base;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_wdata        = '0;
        in_ch.valid      = 1'b0;
        in_ch.octet      = '0;
        in_ch.buffer_end = 1'b0;
        cap_list = '{8'd255, 8'd0, 8'($urandom_range(1, 40)), 8'd16, 8'd250};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: bad start, bad length, header crc error on the last octet, a frame with one data byte
        frame_q = {8'hFF};
        send_buffer();
        frame_q = {START_OCTET_0, START_OCTET_1, 8'h04};
        send_buffer();
        build_frame(0, 8'hFF, 16'hFFFF, 16'h0000);
        frame_q[9] ^= 8'h80;
        send_buffer();
        build_frame(1, 8'h00, 16'h0000, 16'hFFFF);
        send_buffer();

        octet_base = octets_sent;
        foreach (cap_list[p]) begin
            wait_idle();
            write_cap(cap_list[p]);
            phase_end = octet_base + (p + 1) * PHASE_OCTETS;
            // two full blocks under a long hold-off fill both banks and the job queue
            if (p == 3) begin
                hold_reqs++;
                repeat (2) begin
                    build_frame(BLOCK_BYTES, 8'($urandom), 16'($urandom), 16'($urandom));
                    send_buffer();
                end
            end
            do begin
                random_buffer();
            end while (octets_sent < phase_end);
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
